// File: design/lsbc_pkg.sv
package lsbc_pkg;

    localparam int unsigned CW = 32;
    localparam int unsigned DW = CW + 1;
    localparam int unsigned PW = 2 * DW;
    localparam int unsigned QW = 41;
    localparam logic [QW-1:0] QCAP = {1'b1, {(QW-1){1'b0}}};

    localparam logic [2:0] REG_LEFT   = 3'd0;
    localparam logic [2:0] REG_RIGHT  = 3'd1;
    localparam logic [2:0] REG_BOTTOM = 3'd2;
    localparam logic [2:0] REG_TOP    = 3'd3;

    typedef struct packed {
        logic signed [CW-1:0] a0;
        logic signed [CW-1:0] b0;
        logic signed [CW-1:0] a1;
        logic signed [CW-1:0] b1;
    } t_seg;

    typedef struct packed {
        t_seg                 seg;
        logic signed [CW-1:0] edge_v;
        logic                 mv0;
        logic                 mv1;
        logic                 par;
        logic                 neg;
        logic                 ovf;
        logic [DW-1:0]        mda;
    } t_carry;

endpackage

// File: design/line_segment_box_clip.sv
// channel | valid   | stall   | payload
// in      | i_valid | o_stall | i_start_x, i_start_y, i_end_x, i_end_y
// out     | o_valid | i_stall | o_clipped_start_x/_y, o_clipped_end_x/_y
// cfg     | i_cfg_we| -       | i_cfg_idx, i_cfg_data
// One item per cycle unless a result waits under i_stall; four clip units of 45 stages,
// each built around a 41-stage restoring divider.
// Synchronous active-low reset clears all valid bits and box registers.
// The whole pipeline holds while a result waits under i_stall.
module line_segment_box_clip (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [31:0] i_end_x,
    input  logic signed [31:0] i_end_y,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_clipped_start_x,
    output logic signed [31:0] o_clipped_start_y,
    output logic signed [31:0] o_clipped_end_x,
    output logic signed [31:0] o_clipped_end_y,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);

    logic signed [31:0] r_left, r_right, r_bottom, r_top;
    logic ce;
    logic v1, v2, v3, v4;
    lsbc_pkg::t_seg s0, s1, s1y, s2, s2y, s3, s4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_right  <= '0;
            r_bottom <= '0;
            r_top    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lsbc_pkg::REG_LEFT:   r_left   <= i_cfg_data;
                lsbc_pkg::REG_RIGHT:  r_right  <= i_cfg_data;
                lsbc_pkg::REG_BOTTOM: r_bottom <= i_cfg_data;
                lsbc_pkg::REG_TOP:    r_top    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign ce      = !(o_valid && i_stall);
    assign o_stall = !ce;

    assign s0 = '{a0: i_start_x, b0: i_start_y, a1: i_end_x, b1: i_end_y};

    lsbc_clip #(.SIDE_HI(1'b0)) u_left (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ce(ce), .i_valid(i_valid && ce),
        .i_seg(s0), .i_edge(r_left), .o_valid(v1), .o_seg(s1));

    lsbc_clip #(.SIDE_HI(1'b1)) u_right (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ce(ce), .i_valid(v1),
        .i_seg(s1), .i_edge(r_right), .o_valid(v2), .o_seg(s2));

    assign s2y = '{a0: s2.b0, b0: s2.a0, a1: s2.b1, b1: s2.a1};

    lsbc_clip #(.SIDE_HI(1'b0)) u_bottom (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ce(ce), .i_valid(v2),
        .i_seg(s2y), .i_edge(r_bottom), .o_valid(v3), .o_seg(s3));

    lsbc_clip #(.SIDE_HI(1'b1)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ce(ce), .i_valid(v3),
        .i_seg(s3), .i_edge(r_top), .o_valid(v4), .o_seg(s4));

    assign s1y = s4;

    assign o_valid           = v4;
    assign o_clipped_start_x = s1y.b0;
    assign o_clipped_start_y = s1y.a0;
    assign o_clipped_end_x   = s1y.b1;
    assign o_clipped_end_y   = s1y.a1;

`ifndef ASSERT_OFF
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall mismatch");
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && i_cfg_idx == lsbc_pkg::REG_TOP |=> r_top == $past(i_cfg_data))
        else $error("top bound not written");
`endif

endmodule

// File: design/lsbc_clip.sv
module lsbc_clip #(
    parameter bit SIDE_HI = 1'b0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_ce,
    input  logic                          i_valid,
    input  lsbc_pkg::t_seg                i_seg,
    input  logic signed [lsbc_pkg::CW-1:0] i_edge,
    output logic                          o_valid,
    output lsbc_pkg::t_seg                o_seg
);

    localparam int unsigned NS = lsbc_pkg::QW + 4;

    logic [NS-1:0] r_v;

    lsbc_pkg::t_carry r_c0, r_c1;
    lsbc_pkg::t_carry r_cd [0:lsbc_pkg::QW];
    logic [lsbc_pkg::DW-1:0] r_mdb, r_mde;
    logic [lsbc_pkg::PW-1:0] r_prod;
    logic [lsbc_pkg::DW-1:0] r_rem [0:lsbc_pkg::QW];
    logic [lsbc_pkg::QW-1:0] r_low [0:lsbc_pkg::QW];
    logic [lsbc_pkg::QW-1:0] r_q   [0:lsbc_pkg::QW];
    lsbc_pkg::t_seg r_out;

    logic signed [lsbc_pkg::DW-1:0] da, db, de;
    logic out0, out1;
    lsbc_pkg::t_carry n_c0;

    always_comb begin
        da = {i_seg.a1[lsbc_pkg::CW-1], i_seg.a1} - {i_seg.a0[lsbc_pkg::CW-1], i_seg.a0};
        db = {i_seg.b1[lsbc_pkg::CW-1], i_seg.b1} - {i_seg.b0[lsbc_pkg::CW-1], i_seg.b0};
        de = {i_edge[lsbc_pkg::CW-1], i_edge} - {i_seg.a0[lsbc_pkg::CW-1], i_seg.a0};
        if (SIDE_HI) begin
            out0 = i_seg.a0 >= i_edge;
            out1 = i_seg.a1 >= i_edge;
        end else begin
            out0 = i_seg.a0 < i_edge;
            out1 = i_seg.a1 < i_edge;
        end
        n_c0.seg    = i_seg;
        n_c0.edge_v = i_edge;
        n_c0.mv0    = out0;
        n_c0.mv1    = !out0 && out1;
        n_c0.par    = (da == '0);
        n_c0.neg    = (db[lsbc_pkg::DW-1] ^ de[lsbc_pkg::DW-1]) ^ da[lsbc_pkg::DW-1];
        n_c0.ovf    = 1'b0;
        n_c0.mda    = da[lsbc_pkg::DW-1] ? lsbc_pkg::DW'(-da) : lsbc_pkg::DW'(da);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ce) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_c0  <= n_c0;
            r_mdb <= db[lsbc_pkg::DW-1] ? lsbc_pkg::DW'(-db) : lsbc_pkg::DW'(db);
            r_mde <= de[lsbc_pkg::DW-1] ? lsbc_pkg::DW'(-de) : lsbc_pkg::DW'(de);
            r_c1   <= r_c0;
            r_prod <= r_mdb * r_mde;
        end
    end

    logic [lsbc_pkg::PW+lsbc_pkg::QW-1:0] dsh;
    lsbc_pkg::t_carry n_cd0;

    always_comb begin
        dsh = {{lsbc_pkg::PW{1'b0}}, r_c1.mda} << lsbc_pkg::QW;
        n_cd0 = r_c1;
        n_cd0.ovf = {{lsbc_pkg::QW{1'b0}}, r_prod} >= dsh;
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_cd[0]  <= n_cd0;
            r_rem[0] <= lsbc_pkg::DW'(r_prod[lsbc_pkg::PW-1:lsbc_pkg::QW]);
            r_low[0] <= r_prod[lsbc_pkg::QW-1:0];
            r_q[0]   <= '0;
        end
    end

    genvar k;
    generate
        for (k = 0; k < lsbc_pkg::QW; k++) begin : g_div
            logic [lsbc_pkg::DW:0] t;
            logic                  ge;
            always_comb begin
                t  = {r_rem[k], r_low[k][lsbc_pkg::QW-1-k]};
                ge = t >= {1'b0, r_cd[k].mda};
            end
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_cd[k+1]  <= r_cd[k];
                    r_low[k+1] <= r_low[k];
                    r_rem[k+1] <= ge ? lsbc_pkg::DW'(t - {1'b0, r_cd[k].mda})
                                     : lsbc_pkg::DW'(t);
                    r_q[k+1]   <= {r_q[k][lsbc_pkg::QW-2:0], ge};
                end
            end
        end
    endgenerate

    lsbc_pkg::t_carry cf;
    logic [lsbc_pkg::QW-1:0] q;
    logic signed [lsbc_pkg::QW+1:0] wide, bx;
    logic signed [lsbc_pkg::CW-1:0] res;
    lsbc_pkg::t_seg n_out;

    always_comb begin
        cf = r_cd[lsbc_pkg::QW];
        q  = (cf.ovf || r_q[lsbc_pkg::QW] > lsbc_pkg::QCAP) ? lsbc_pkg::QCAP
                                                            : r_q[lsbc_pkg::QW];
        bx = (lsbc_pkg::QW+2)'(cf.seg.b0);
        wide = cf.neg ? bx - $signed({2'b00, q}) : bx + $signed({2'b00, q});
        if (wide > (lsbc_pkg::QW+2)'(32'sh7fffffff)) begin
            res = 32'sh7fffffff;
        end else if (wide < -(lsbc_pkg::QW+2)'(33'sh080000000)) begin
            res = 32'sh80000000;
        end else begin
            res = wide[lsbc_pkg::CW-1:0];
        end
        n_out = cf.seg;
        if (cf.mv0) begin
            n_out.a0 = cf.edge_v;
            if (!cf.par) begin
                n_out.b0 = res;
            end
        end else if (cf.mv1) begin
            n_out.a1 = cf.edge_v;
            if (!cf.par) begin
                n_out.b1 = res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_seg   = r_out;

`ifndef ASSERT_OFF
    a_one_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] |-> !(r_c0.mv0 && r_c0.mv1))
        else $error("both endpoints selected");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ce |=> $stable(r_v) && $stable(r_out))
        else $error("pipeline moved while held");
    a_qcap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NS-2] |-> q <= lsbc_pkg::QCAP)
        else $error("quotient above cap");
`endif

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int          LATENCY     = 180;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          HOLD_CYCLES = 500;
    localparam logic [2:0]  REG_SPARE   = 3'd4;
    localparam logic [2:0]  REG_LAST    = 3'd7;
    localparam longint      UNIT        = 64'sd65536;

    typedef struct {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
    } t_ends;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [31:0] i_start_x = '0;
    logic signed [31:0] i_start_y = '0;
    logic signed [31:0] i_end_x = '0;
    logic signed [31:0] i_end_y = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_clipped_start_x;
    logic signed [31:0] o_clipped_start_y;
    logic signed [31:0] o_clipped_end_x;
    logic signed [31:0] o_clipped_end_y;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [31:0]        i_cfg_data = '0;

    line_segment_box_clip uut (.*);

    always #5 i_clk = ~i_clk;

    longint box_l, box_r, box_b, box_t;
    t_ends  clipped_q[$];
    int     n_sent, n_checked, n_errors, n_cycles, hold_left, rx_wait;
    bit     no_idle;

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint cross_at(longint a0, longint b0, longint a1, longint b1,
                                        longint e, longint keep);
        longint     da, db, de, r;
        bit [127:0] prod, q;
        bit         neg;
        da = a1 - a0;
        db = b1 - b0;
        de = e - a0;
        if (da == 0)
            return keep;
        neg  = ((db < 0) != (de < 0)) != (da < 0);
        prod = 128'(mag(db)) * 128'(mag(de));
        q    = prod / 128'(mag(da));
        if (q > 128'(lsbc_pkg::QCAP))
            q = 128'(lsbc_pkg::QCAP);
        r = neg ? b0 - longint'(q) : b0 + longint'(q);
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r;
    endfunction

    function automatic t_ends clip_to_box(t_ends s);
        longint x0, y0, x1, y1;
        t_ends  o;
        x0 = s.sx; y0 = s.sy; x1 = s.ex; y1 = s.ey;
        if (x0 < box_l) begin
            y0 = cross_at(x0, y0, x1, y1, box_l, y0); x0 = box_l;
        end else if (x1 < box_l) begin
            y1 = cross_at(x0, y0, x1, y1, box_l, y1); x1 = box_l;
        end
        if (x0 >= box_r) begin
            y0 = cross_at(x0, y0, x1, y1, box_r, y0); x0 = box_r;
        end else if (x1 >= box_r) begin
            y1 = cross_at(x0, y0, x1, y1, box_r, y1); x1 = box_r;
        end
        if (y0 < box_b) begin
            x0 = cross_at(y0, x0, y1, x1, box_b, x0); y0 = box_b;
        end else if (y1 < box_b) begin
            x1 = cross_at(y0, x0, y1, x1, box_b, x1); y1 = box_b;
        end
        if (y0 >= box_t) begin
            x0 = cross_at(y0, x0, y1, x1, box_t, x0); y0 = box_t;
        end else if (y1 >= box_t) begin
            x1 = cross_at(y0, x0, y1, x1, box_t, x1); y1 = box_t;
        end
        o.sx = x0[31:0]; o.sy = y0[31:0]; o.ex = x1[31:0]; o.ey = y1[31:0];
        return o;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_checked);
        n_errors++;
    endtask

    // receiver: random stall per result, plus the long hold
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (rx_wait > 0) begin
            i_stall <= 1'b1;
            rx_wait <= rx_wait - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_ends want;
        if (i_rst_n && o_valid && !i_stall) begin
            rx_wait <= no_idle ? 0 : $urandom_range(0, 3);
            if (clipped_q.size() == 0) begin
                report("unexpected result", o_clipped_start_x, 32'h0);
            end else begin
                want = clipped_q.pop_front();
                if (o_clipped_start_x !== want.sx) report("start_x", o_clipped_start_x, want.sx);
                if (o_clipped_start_y !== want.sy) report("start_y", o_clipped_start_y, want.sy);
                if (o_clipped_end_x !== want.ex)   report("end_x", o_clipped_end_x, want.ex);
                if (o_clipped_end_y !== want.ey)   report("end_y", o_clipped_end_y, want.ey);
            end
            n_checked++;
        end
    end

    task automatic send_segment(longint sx, longint sy, longint ex, longint ey);
        t_ends s;
        int    gap;
        s.sx = sx[31:0]; s.sy = sy[31:0]; s.ex = ex[31:0]; s.ey = ey[31:0];
        gap  = no_idle ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid   = 1'b1;
        i_start_x = s.sx;
        i_start_y = s.sy;
        i_end_x   = s.ex;
        i_end_y   = s.ey;
        do @(posedge i_clk); while (o_stall);
        clipped_q.push_back(clip_to_box(s));
        n_sent++;
    endtask

    task automatic drain;
        @(negedge i_clk);
        i_valid = 1'b0;
        while (clipped_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, longint value);
        drain();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value[31:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            lsbc_pkg::REG_LEFT:   box_l = longint'($signed(value[31:0]));
            lsbc_pkg::REG_RIGHT:  box_r = longint'($signed(value[31:0]));
            lsbc_pkg::REG_BOTTOM: box_b = longint'($signed(value[31:0]));
            lsbc_pkg::REG_TOP:    box_t = longint'($signed(value[31:0]));
            default: ;
        endcase
    endtask

    task automatic set_box(longint l, longint r, longint b, longint t);
        write_reg(lsbc_pkg::REG_LEFT, l);
        write_reg(lsbc_pkg::REG_RIGHT, r);
        write_reg(lsbc_pkg::REG_BOTTOM, b);
        write_reg(lsbc_pkg::REG_TOP, t);
    endtask

    function automatic longint near(longint c, longint span);
        return longint'($signed(32'(c + longint'($urandom_range(0, 32'(2 * span))) - span)));
    endfunction

    function automatic longint any32();
        return longint'($signed($urandom()));
    endfunction

    task automatic test_directed;
        longint lo, hi;
        lo = -64'sd2147483648;
        hi = 64'sd2147483647;
        // reset box is all zeros
        send_segment(-UNIT, -UNIT, UNIT, UNIT);
        send_segment(lo, lo, hi, hi);
        set_box(-10 * UNIT, 10 * UNIT, -10 * UNIT, 10 * UNIT);
        send_segment(UNIT, 2 * UNIT, 3 * UNIT, -4 * UNIT);
        send_segment(-20 * UNIT, 0, 5 * UNIT, 5 * UNIT);
        send_segment(5 * UNIT, 5 * UNIT, -20 * UNIT, -3 * UNIT);
        send_segment(20 * UNIT, UNIT, 0, -UNIT);
        send_segment(0, -30 * UNIT, UNIT, 0);
        send_segment(0, 0, 2 * UNIT, 30 * UNIT);
        send_segment(-15 * UNIT, 3 * UNIT, -15 * UNIT, 7 * UNIT);
        send_segment(-15 * UNIT, -20 * UNIT, 25 * UNIT, 40 * UNIT);
        send_segment(30 * UNIT, 30 * UNIT, 40 * UNIT, 50 * UNIT);
        send_segment(lo, lo, hi, hi);
        send_segment(hi, hi, lo, lo);
        send_segment(lo, hi, hi, lo);
        send_segment(lo, lo, lo, lo);
        send_segment(hi, hi, hi, hi);
        send_segment(lo, lo, lo + 1, hi);
        send_segment(0, 0, 0, 0);
        send_segment(10 * UNIT, 10 * UNIT, 10 * UNIT, -10 * UNIT);
        set_box(lo, hi, lo, hi);
        send_segment(lo, lo, hi, hi);
        send_segment(hi, 0, 0, hi);
        set_box(10 * UNIT, -10 * UNIT, 5 * UNIT, -5 * UNIT);
        send_segment(-UNIT, -UNIT, UNIT, UNIT);
        send_segment(lo, hi, hi, lo);
        write_reg(REG_SPARE, UNIT);
        write_reg(REG_LAST, -UNIT);
        send_segment(UNIT, 3 * UNIT, -7 * UNIT, 2 * UNIT);
    endtask

    task automatic test_random_boxes(int phases, int per_phase);
        longint a, b, c, d, w, cx, cy;
        for (int p = 0; p < phases; p++) begin
            no_idle = (p % 3 == 2);
            if (p % 4 == 3) begin
                a = any32(); b = any32(); c = any32(); d = any32();
                if (p % 8 == 3) begin
                    if (a > b) begin w = a; a = b; b = w; end
                    if (c > d) begin w = c; c = d; d = w; end
                end
                set_box(a, b, c, d);
            end else begin
                cx = near(0, 1 << 28);
                cy = near(0, 1 << 28);
                w  = $urandom_range(1, 1 << 24);
                set_box(cx - w, cx + w, cy - w / 2, cy + w / 2);
            end
            cx = (box_l >>> 1) + (box_r >>> 1);
            cy = (box_b >>> 1) + (box_t >>> 1);
            w  = mag(box_r - box_l) + 16;
            if (w > (1 << 29)) w = 1 << 29;
            for (int k = 0; k < per_phase; k++) begin
                case ($urandom_range(0, 9))
                    0, 1: send_segment(any32(), any32(), any32(), any32());
                    2: begin
                        a = near(cx, 2 * w);
                        send_segment(a, near(cy, 2 * w), a, near(cy, 2 * w));
                    end
                    3: begin
                        a = near(cy, 2 * w);
                        send_segment(near(cx, 2 * w), a, near(cx, 2 * w), a);
                    end
                    default: send_segment(near(cx, 2 * w), near(cy, 2 * w),
                                          near(cx, 2 * w), near(cy, 2 * w));
                endcase
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure(int count);
        set_box(-100 * UNIT, 100 * UNIT, -50 * UNIT, 50 * UNIT);
        no_idle   = 1'b1;
        hold_left = HOLD_CYCLES;
        for (int k = 0; k < count; k++)
            send_segment(near(0, 200 * UNIT), near(0, 200 * UNIT),
                         near(0, 200 * UNIT), near(0, 200 * UNIT));
        no_idle = 1'b0;
    endtask

    initial begin
        box_l = 0; box_r = 0; box_b = 0; box_t = 0;
        n_sent = 0; n_checked = 0; n_errors = 0; n_cycles = 0;
        hold_left = 0; rx_wait = 0; no_idle = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_backpressure(250);
        test_random_boxes(8, 85);
        drain();
        repeat (LATENCY + 20) @(posedge i_clk);
        $display("covered %0d segments over directed, back-pressure and random boxes",
                 n_sent);
        $display("checked %0d clipped results, %0d mismatches", n_checked, n_errors);
        if (n_errors == 0 && clipped_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
design/lsbc_pkg.sv
design/lsbc_clip.sv
design/line_segment_box_clip.sv
dv/tb_top.sv
